### rtl/tsp_pkg.sv
package tsp_pkg;

  localparam int unsigned TickRateHz  = 10000;
  localparam int unsigned MaxStepRate = 5000;

  localparam logic [15:0] DecelCap   = 16'(TickRateHz / 10);
  localparam logic [15:0] ShortReset = 16'(TickRateHz / 1000);
  localparam logic [23:0] MinSpeedFx = 24'(100 << 10);
  localparam logic [23:0] VelMax     = 24'hFF_FFFF;
  localparam logic [47:0] Floor2     = 48'(64'd10000 << 20);
  localparam logic [47:0] TickNum    = 48'(64'(TickRateHz) << 10);

  typedef enum logic [3:0] {
    K_TICK   = 4'd0,
    K_MOVE   = 4'd1,
    K_MOVETO = 4'd2,
    K_HOME   = 4'd3,
    K_STOP   = 4'd4,
    K_SSTOP  = 4'd5,
    K_SETPOS = 4'd6,
    K_ENA    = 4'd7,
    K_DIS    = 4'd8
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_HOMING = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    CFG_MAXV  = 2'd0,
    CFG_ACCEL = 2'd1,
    CFG_LIMP  = 2'd2,
    CFG_LIML  = 2'd3
  } cfg_e;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SQRT,      // root of operand register
    OP_DIV,       // divide num by den
    OP_MUL        // multiply a by b
  } op_e;

  typedef struct packed {
    logic        start;
    op_e         op;
    logic [47:0] a;
    logic [47:0] b;
  } dp_cmd_t;

  typedef struct packed {
    logic        done;
    logic [47:0] res;
  } dp_sts_t;

endpackage

### rtl/tsp_datapath.sv
module tsp_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tsp_pkg::dp_cmd_t cmd_i,
  output tsp_pkg::dp_sts_t sts_o
);
  import tsp_pkg::*;

  // Shared iterative unit: square root bit by bit, one quotient bit per cycle
  // for divide, 16x48 partial products for multiply; no new command while busy.
  logic        busy_q, busy_d;
  op_e         op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [47:0] x_q, x_d, r_q, r_d, b_q, b_d;
  logic [95:0] p_q, p_d;
  logic        done_q, done_d;

  logic [48:0] trial;
  logic [47:0] sbit;
  logic [48:0] rem;
  logic [63:0] pp;

  always_comb begin
    busy_d = busy_q; op_d = op_q; cnt_d = cnt_q;
    x_d = x_q; r_d = r_q; b_d = b_q; p_d = p_q; done_d = 1'b0;
    sbit  = 48'd1 << {cnt_q[4:0], 1'b0};
    trial = {1'b0, r_q} + {1'b0, sbit};
    rem   = {p_q[47:0], x_q[47]};
    pp    = 64'(x_q[15:0]) * 64'(b_q[47:0]);
    if (!busy_q) begin
      if (cmd_i.start) begin
        busy_d = 1'b1;
        op_d   = cmd_i.op;
        x_d    = cmd_i.a;
        b_d    = cmd_i.b;
        r_d    = '0;
        p_d    = '0;
        unique case (cmd_i.op)
          OP_SQRT: cnt_d = 6'd23;
          OP_DIV:  cnt_d = 6'd47;
          OP_MUL:  cnt_d = 6'd2;
          default: cnt_d = 6'd0;
        endcase
      end
    end else begin
      unique case (op_q)
        OP_SQRT: begin
          if ({1'b0, x_q} >= trial) begin
            x_d = x_q - trial[47:0];
            r_d = (r_q >> 1) + sbit;
          end else begin
            r_d = r_q >> 1;
          end
        end
        OP_DIV: begin
          x_d = x_q << 1;
          if (rem >= {1'b0, b_q}) begin
            p_d[47:0] = 48'(rem - {1'b0, b_q});
            r_d = {r_q[46:0], 1'b1};
          end else begin
            p_d[47:0] = rem[47:0];
            r_d = {r_q[46:0], 1'b0};
          end
        end
        OP_MUL: begin
          p_d = p_q + (96'(pp) << {cnt_q[1:0] == 2'd2 ? 6'd0 :
                 cnt_q[1:0] == 2'd1 ? 6'd16 : 6'd32});
          x_d = x_q >> 16;
          if (cnt_q == 6'd0) r_d = p_d[47:0];
        end
        default: ;
      endcase
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0; done_d = 1'b1;
        if (op_q == OP_MUL) r_d = p_d[47:0];
      end else begin
        cnt_d = cnt_q - 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; op_q <= OP_NONE; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; op_q <= op_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; r_q <= r_d; b_q <= b_d; p_q <= p_d;
  end

  assign sts_o.done = done_q;
  assign sts_o.res  = r_q;

endmodule

### rtl/tsp_ctrl.sv
module tsp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] amount_i,
  input  logic               limit_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               step_pulse_o,
  output logic               dir_level_o,
  output logic               driver_enable_n_o,
  output logic signed [31:0] position_o,
  output logic [2:0]         motion_phase_o,
  output logic               home_found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output tsp_pkg::dp_cmd_t   cmd_o,
  input  tsp_pkg::dp_sts_t   sts_i
);
  import tsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_MV_MUL, S_MV_DIV, S_MV_SQ, S_MV_IV, S_MV_END,
    S_HM_DIV,
    S_SS_MUL, S_SS_DIV,
    S_UP_MUL, S_UP_SQ, S_UP_IV, S_UP_END,
    S_CF_DIV,
    S_OUT
  } state_e;

  state_e      st_q;
  logic        busy_q;
  logic [3:0]  kind_q;
  logic [31:0] amt_q;
  logic        lvl_q;

  logic [15:0] maxv_q, accel_q, short_q;
  logic        limp_q, liml_q;
  phase_e      ph_q;
  logic        ena_q, neg_q;
  logic [31:0] pos_q, left_q, done_q, alen_q, clen_q, mag_q;
  logic [23:0] vel_q;
  logic [15:0] ivl_q, cnt_q;
  logic        pulse_q, found_q, is_acc_q;

  logic        ov_q;
  logic        rp_q, rdir_q, ren_q, rfd_q;
  logic [31:0] rpos_q;
  logic [2:0]  rph_q;

  logic [31:0] steps, mag;
  logic [16:0] two_a;
  logic [47:0] res;
  logic [15:0] cw, iv16;
  logic [47:0] sub;

  assign res   = sts_i.res;
  assign two_a = {accel_q, 1'b0};
  assign steps = (kind_q == K_MOVETO) ? amt_q - pos_q : amt_q;
  assign mag   = steps[31] ? 32'(0) - steps : steps;
  assign sub   = 48'(two_a) << 20;
  assign iv16  = (res > 48'hFFFF) ? 16'hFFFF : res[15:0];
  assign cw    = (cfg_data_i == 16'd0) ? 16'd1 :
                 (cfg_data_i > 16'(MaxStepRate)) ? 16'(MaxStepRate) : cfg_data_i;

  // a pending register write wins over a command
  assign in_stall_o  = busy_q || ov_q || (st_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = !busy_q && (st_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign step_pulse_o = rp_q;
  assign dir_level_o  = rdir_q;
  assign driver_enable_n_o = ren_q;
  assign position_o   = rpos_q;
  assign motion_phase_o = rph_q;
  assign home_found_o = rfd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; busy_q <= 1'b0; ov_q <= 1'b0;
      maxv_q <= 16'd1000; accel_q <= 16'd500; short_q <= ShortReset;
      limp_q <= 1'b0; liml_q <= 1'b0;
      ph_q <= PH_IDLE; ena_q <= 1'b0; neg_q <= 1'b0;
      pos_q <= '0; left_q <= '0; done_q <= '0; alen_q <= '0; clen_q <= '0;
      vel_q <= '0; ivl_q <= '0; cnt_q <= '0; mag_q <= '0;
      pulse_q <= 1'b0; found_q <= 1'b0; is_acc_q <= 1'b0;
      cmd_o <= '0;
      kind_q <= '0; amt_q <= '0; lvl_q <= 1'b0;
      rp_q <= 1'b0; rdir_q <= 1'b1; ren_q <= 1'b1; rfd_q <= 1'b0;
      rpos_q <= '0; rph_q <= '0;
    end else begin
      // start is a one-cycle strobe; a new command never follows it directly
      if (cmd_o.start) cmd_o.start <= 1'b0;
      if (ov_q && !out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: begin
          if (cfg_valid_i && cfg_ready_o) begin
            unique case (cfg_e'(cfg_index_i))
              CFG_MAXV: begin
                maxv_q <= cw;
                cmd_o <= '{start: 1'b1, op: OP_DIV, a: 48'(TickRateHz), b: 48'(cw)};
                st_q <= S_CF_DIV;
              end
              CFG_ACCEL: accel_q <= (cfg_data_i == 16'd0) ? 16'd1 : cfg_data_i;
              CFG_LIMP:  limp_q <= cfg_data_i[0];
              CFG_LIML:  liml_q <= cfg_data_i[0];
              default: ;
            endcase
          end else if (in_valid_i && !in_stall_o) begin
            kind_q <= kind_i; amt_q <= amount_i; lvl_q <= limit_level_i;
            busy_q <= 1'b1; pulse_q <= 1'b0; found_q <= 1'b0;
            st_q <= S_DECODE;
          end
        end
        S_CF_DIV: if (sts_i.done) begin
          short_q <= (res == 48'd0) ? 16'd1 : iv16;
          st_q <= S_IDLE;
        end
        S_DECODE: begin
          state_e st_d;
          st_d = S_OUT;
          case (kind_q)
            K_TICK: if (ph_q != PH_IDLE) begin
              if (cnt_q != 16'd0) cnt_q <= cnt_q - 16'd1;
              else begin
                cnt_q <= ivl_q;
                if (ph_q == PH_HOMING && limp_q && lvl_q == liml_q) begin
                  ph_q <= PH_IDLE; pos_q <= '0; left_q <= '0; found_q <= 1'b1;
                end else begin
                  pulse_q <= 1'b1;
                  pos_q <= neg_q ? pos_q - 32'd1 : pos_q + 32'd1;
                  left_q <= left_q - 32'd1;
                  done_q <= done_q + 32'd1;
                  if (left_q == 32'd1) ph_q <= PH_IDLE;
                  else if (ph_q == PH_ACCEL || ph_q == PH_DECEL) begin
                    is_acc_q <= (ph_q == PH_ACCEL);
                    cmd_o <= '{start: 1'b1, op: OP_MUL, a: 48'(vel_q), b: 48'(vel_q)};
                    st_d = S_UP_MUL;
                  end else if (ph_q == PH_CRUISE) begin
                    if (33'(done_q) + 33'd1 >= 33'(alen_q) + 33'(clen_q)) ph_q <= PH_DECEL;
                  end
                end
              end
            end
            K_MOVE, K_MOVETO: if (steps != 32'd0 && ena_q) begin
              neg_q <= steps[31];
              mag_q <= mag; left_q <= mag;
              cmd_o <= '{start: 1'b1, op: OP_MUL, a: 48'(maxv_q), b: 48'(maxv_q)};
              st_d = S_MV_MUL;
            end
            K_HOME: if (ena_q && limp_q) begin
              neg_q <= !(amt_q != 32'd0 && !amt_q[31]);
              left_q <= 32'h7FFF_FFFF;
              cmd_o <= '{start: 1'b1, op: OP_DIV, a: 48'(TickRateHz),
                         b: (maxv_q[15:2] == 14'd0) ? 48'd1 : 48'(maxv_q[15:2])};
              st_d = S_HM_DIV;
            end
            K_STOP: begin ph_q <= PH_IDLE; left_q <= '0; end
            K_SSTOP: if (ph_q != PH_IDLE) begin
              cmd_o <= '{start: 1'b1, op: OP_MUL, a: 48'(vel_q), b: 48'(vel_q)};
              st_d = S_SS_MUL;
            end
            K_SETPOS: pos_q <= amt_q;
            K_ENA: ena_q <= 1'b1;
            K_DIS: begin ena_q <= 1'b0; ph_q <= PH_IDLE; end
            default: ;
          endcase
          st_q <= st_d;
        end
        S_HM_DIV: if (sts_i.done) begin
          ivl_q <= (iv16 < short_q) ? short_q : iv16;
          cnt_q <= (iv16 < short_q) ? short_q : iv16;
          ph_q <= PH_HOMING; st_q <= S_OUT;
        end
        S_SS_MUL: if (sts_i.done) begin
          // v^2 in Q.20 down to whole steps^2/s^2
          cmd_o <= '{start: 1'b1, op: OP_DIV, a: 48'(res[47:20]), b: 48'(two_a)};
          st_q <= S_SS_DIV;
        end
        S_SS_DIV: if (sts_i.done) begin
          if (res == 48'd0) begin ph_q <= PH_IDLE; left_q <= '0; end
          else begin
            left_q <= res[31:0]; clen_q <= '0; alen_q <= '0; ph_q <= PH_DECEL;
          end
          st_q <= S_OUT;
        end
        S_MV_MUL: if (sts_i.done) begin
          cmd_o <= '{start: 1'b1, op: OP_DIV, a: res, b: 48'(two_a)};
          st_q <= S_MV_DIV;
        end
        S_MV_DIV: if (sts_i.done) begin
          if ({res, 1'b0} >= 49'(mag_q)) begin
            alen_q <= mag_q >> 1; clen_q <= '0;
          end else begin
            alen_q <= res[31:0]; clen_q <= mag_q - {res[30:0], 1'b0};
          end
          cmd_o <= '{start: 1'b1, op: OP_SQRT, a: 48'(two_a) << 20, b: '0};
          st_q <= S_MV_SQ;
        end
        S_MV_SQ: if (sts_i.done) begin
          vel_q <= (res < 48'(MinSpeedFx)) ? MinSpeedFx : res[23:0];
          cmd_o <= '{start: 1'b1, op: OP_DIV, a: TickNum,
                     b: (res < 48'(MinSpeedFx)) ? 48'(MinSpeedFx) : res};
          st_q <= S_MV_IV;
        end
        S_MV_IV: if (sts_i.done) begin
          ivl_q <= (iv16 < short_q) ? short_q : iv16;
          cnt_q <= (iv16 < short_q) ? short_q : iv16;
          done_q <= '0; ph_q <= PH_ACCEL; st_q <= S_OUT;
        end
        S_UP_MUL: if (sts_i.done) begin
          if (is_acc_q) begin
            cmd_o <= '{start: 1'b1, op: OP_SQRT, a: res + sub, b: '0};
            st_q <= S_UP_SQ;
          end else if (res < sub || res - sub < Floor2) begin
            vel_q <= MinSpeedFx;
            cmd_o <= '{start: 1'b1, op: OP_DIV, a: TickNum, b: 48'(MinSpeedFx)};
            st_q <= S_UP_IV;
          end else begin
            cmd_o <= '{start: 1'b1, op: OP_SQRT, a: res - sub, b: '0};
            st_q <= S_UP_SQ;
          end
        end
        S_UP_SQ: if (sts_i.done) begin
          logic [47:0] cap, v;
          cap = 48'(maxv_q) << 10;
          v = (res > 48'(VelMax)) ? 48'(VelMax) : res;
          if (is_acc_q && v > cap) v = cap;
          vel_q <= v[23:0];
          cmd_o <= '{start: 1'b1, op: OP_DIV, a: TickNum, b: v};
          st_q <= S_UP_IV;
        end
        S_UP_IV: if (sts_i.done) begin
          if (is_acc_q) begin
            ivl_q <= (iv16 < short_q) ? short_q : iv16;
            if (done_q >= alen_q) ph_q <= (clen_q != 32'd0) ? PH_CRUISE : PH_DECEL;
          end else begin
            ivl_q <= (iv16 > DecelCap) ? DecelCap : iv16;
          end
          st_q <= S_OUT;
        end
        S_OUT: begin
          ov_q <= 1'b1; busy_q <= 1'b0;
          rp_q <= pulse_q; rdir_q <= !neg_q; ren_q <= !ena_q;
          rpos_q <= pos_q; rph_q <= ph_q; rfd_q <= found_q;
          st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/trapezoid_stepper_profile_unit.sv
// Trapezoidal stepper motion profile unit.
// Input channel: in_valid_i / in_stall_o carries one command transaction
// (kind, amount, limit_level). Every input transaction produces exactly one
// result transaction on out_valid_o / out_stall_i (step pulse, direction,
// driver enable, position, motion phase, home found).
// Config channel: cfg_valid_i / cfg_ready_o with a register index and data;
// write it only while no command is in flight. A pending write stalls input.
// A max velocity write holds cfg_ready_o low for one divide.
// A command without arithmetic goes from decode straight to the output
// state. Others run on the shared iterative unit: a step that updates
// speed takes a multiply, a root and a divide (a multiply and a divide when
// deceleration hits the speed floor), a smooth stop a multiply and a divide,
// a homing start one divide, a move start a multiply, a divide, a root and
// a divide. One command is in flight at a time; the next one can be taken,
// at the earliest, in the cycle after the result transaction.
// Reset: registers return to max velocity 1000, acceleration 500, no limit
// switch, driver disabled, idle at position 0.
// A stalled receiver holds the result and blocks new commands.
module trapezoid_stepper_profile_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         kind_i,
  input  logic signed [31:0] amount_i,
  input  logic               limit_level_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               step_pulse_o,
  output logic               dir_level_o,
  output logic               driver_enable_n_o,
  output logic signed [31:0] position_o,
  output logic [2:0]         motion_phase_o,
  output logic               home_found_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import tsp_pkg::*;

  dp_cmd_t cmd;  // controller to arithmetic unit
  dp_sts_t sts;  // completion and result

  tsp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .amount_i,
    .limit_level_i, .out_valid_o, .out_stall_i, .step_pulse_o, .dir_level_o,
    .driver_enable_n_o, .position_o, .motion_phase_o, .home_found_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  tsp_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts)
  );

endmodule
